// ----- src/msbb_pkg.sv -----
package msbb_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned CHUNK_W  = 5;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned EXP_W    = 6;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = CHUNK_W;
  localparam int unsigned OUT_PAD_W = 2;
  localparam int unsigned TDATA_O_W = 2 * DATA_W + LEN_W + OUT_PAD_W;

  localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MSB    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MSB2   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BITS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUSIVE_BOUND = 2'd2;

  localparam logic [MODE_W-1:0]  RST_SYMBOL_MODE     = MODE_DIRECT;
  localparam logic [CHUNK_W-1:0] RST_CHUNK_BITS      = 5'd8;
  localparam logic               RST_INCLUSIVE_BOUND = 1'b1;

  // sequencer -> datapath
  typedef struct packed {
    logic load;
    logic shift_one;
    logic add_base;
    logic chunk_adv;
    logic cnt_dec;
  } msbb_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic passes;
    logic cnt_zero;
    logic chunk_cond;
    logic sym_ge_thr;
  } msbb_stat_t;

  // chunk width 0 behaves as 1
  function automatic logic [CHUNK_W-1:0] eff_chunk(input logic [CHUNK_W-1:0] b);
    logic [CHUNK_W-1:0] r;
    r = (b == '0) ? CHUNK_W'(1) : b;
    return r;
  endfunction

endpackage

// ----- src/msbb_dpath.sv -----
module msbb_dpath
  import msbb_pkg::*;
(
  input  logic                clk_i,
  input  msbb_ctrl_t          ctrl_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [CHUNK_W-1:0]  chunk_i,
  input  logic                incl_i,
  output msbb_stat_t          stat_o,
  output logic [DATA_W-1:0]   coded_o,
  output logic [DATA_W-1:0]   esc_o,
  output logic [LEN_W-1:0]    len_o
);

  logic [DATA_W-1:0]  v_q, sym_q, base_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [EXP_W-1:0]   exp_q;
  logic [CHUNK_W-1:0] cnt_q;

  logic [DATA_W-1:0] thr, pow, mask;
  logic              in_passes, v_over_pow;

  always_comb begin
    thr = DATA_W'(1) << chunk_i;
    pow = DATA_W'(1) << exp_q[EXP_W-2:0];
    in_passes  = incl_i ? (value_i <= thr) : (value_i < thr);
    v_over_pow = incl_i ? (v_q > pow) : (v_q >= pow);
    mask = ~({DATA_W{1'b1}} << shift_q);
  end

  // bound exponent at or above 32 can never be exceeded by a 32-bit value
  assign stat_o.passes     = in_passes;
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.chunk_cond = !exp_q[EXP_W-1] && v_over_pow;
  assign stat_o.sym_ge_thr = (sym_q >= thr);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q     <= value_i;
      sym_q   <= value_i;
      base_q  <= '0;
      shift_q <= '0;
      exp_q   <= EXP_W'(chunk_i);
      cnt_q   <= '0;
    end else begin
      if (ctrl_i.shift_one) begin
        sym_q   <= sym_q >> 1;
        shift_q <= shift_q + SHIFT_W'(1);
      end
      if (ctrl_i.add_base) begin
        base_q <= base_q + thr;
      end
      if (ctrl_i.chunk_adv) begin
        exp_q <= exp_q + EXP_W'(chunk_i);
        cnt_q <= chunk_i;
      end else if (ctrl_i.cnt_dec) begin
        cnt_q <= cnt_q - CHUNK_W'(1);
      end
    end
  end

  assign coded_o = sym_q + base_q;
  assign esc_o   = v_q & mask;
  assign len_o   = LEN_W'(shift_q);

endmodule

// ----- src/msbb_seq.sv -----
module msbb_seq
  import msbb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  msbb_stat_t         stat_i,
  input  logic               out_free_i,
  output msbb_ctrl_t         ctrl_o,
  output logic               out_load_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          if (!stat_i.passes && (mode_i inside {MODE_MSB, MODE_MSB2})) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        if (mode_i == MODE_MSB) begin
          // drain the current chunk one bit a cycle, then test the next bound
          if (!stat_i.cnt_zero) begin
            ctrl_o.shift_one = 1'b1;
            ctrl_o.cnt_dec   = 1'b1;
          end else if (stat_i.chunk_cond) begin
            ctrl_o.add_base  = 1'b1;
            ctrl_o.chunk_adv = 1'b1;
          end else begin
            state_d = ST_FIN;
          end
        end else if (mode_i == MODE_MSB2) begin
          if (stat_i.sym_ge_thr) begin
            ctrl_o.shift_one = 1'b1;
            ctrl_o.add_base  = 1'b1;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/msbb_out_stage.sv -----
module msbb_out_stage
  import msbb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [DATA_W-1:0]     coded_i,
  input  logic [DATA_W-1:0]     esc_i,
  input  logic [LEN_W-1:0]      len_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [TDATA_O_W-1:0]  data_o
);

  logic                 valid_q;
  logic [TDATA_O_W-1:0] data_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {{OUT_PAD_W{1'b0}}, len_i, esc_i, coded_i};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/msb_symbol_bucketer.sv -----
// Direct mode or a passing value goes from accept to the finish state, then to the output register.
// msb_2 mode shifts one escape bit per step; msb mode also tests each chunk bound before draining it.
// Worst case: chunk width 1, 31 one-bit shifts plus 32 bound tests.
// One item at a time: the shared one-bit shifter/adder sets the rate; the next
// item is taken the cycle after the result moves into the output register.
// Reset: symbol_mode 0, chunk_bits 8, inclusive_bound 1, output register empty.
module msb_symbol_bucketer
  import msbb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,   // [31:0] value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_O_W-1:0]  m_axis_tdata,   // [31:0] coded_symbol, [63:32] escape_bits,
                                                // [69:64] escape_length, [71:70] zero
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  logic [MODE_W-1:0]  symbol_mode_q;
  logic [CHUNK_W-1:0] chunk_bits_q;
  logic               inclusive_bound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_mode_q     <= RST_SYMBOL_MODE;
      chunk_bits_q      <= RST_CHUNK_BITS;
      inclusive_bound_q <= RST_INCLUSIVE_BOUND;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYMBOL_MODE:     symbol_mode_q     <= cfg_data_i[MODE_W-1:0];
        REG_CHUNK_BITS:      chunk_bits_q      <= cfg_data_i[CHUNK_W-1:0];
        REG_INCLUSIVE_BOUND: inclusive_bound_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  msbb_ctrl_t        ctrl;
  msbb_stat_t        stat;
  logic [DATA_W-1:0] coded, esc;
  logic [LEN_W-1:0]  len;
  logic              out_free, out_load;

  msbb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (symbol_mode_q),
    .stat_i     (stat),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .out_load_o (out_load)
  );

  msbb_dpath u_dpath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (s_axis_tdata),
    .chunk_i (eff_chunk(chunk_bits_q)),
    .incl_i  (inclusive_bound_q),
    .stat_o  (stat),
    .coded_o (coded),
    .esc_o   (esc),
    .len_o   (len)
  );

  msbb_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .coded_i (coded),
    .esc_i   (esc),
    .len_i   (len),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

// ----- dv/msb_symbol_bucketer_tb.sv -----
`timescale 1ns / 1ps

module msb_symbol_bucketer_tb;
  import msbb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTED = 20;

  typedef struct packed {
    logic [LEN_W-1:0]  escape_length;
    logic [DATA_W-1:0] escape_bits;
    logic [DATA_W-1:0] coded_symbol;
  } bucket_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;    // [31:0] value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_O_W-1:0] m_axis_tdata;    // [31:0] coded_symbol, [63:32] escape_bits,
                                         // [69:64] escape_length, [71:70] zero
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // register shadow used by the predictor
  logic [MODE_W-1:0]  cur_mode  = RST_SYMBOL_MODE;
  logic [CHUNK_W-1:0] cur_chunk = RST_CHUNK_BITS;
  logic               cur_incl  = RST_INCLUSIVE_BOUND;

  bucket_t     expected_buckets[$];
  bucket_t     want_b;
  int unsigned mismatches = 0;
  int unsigned n_checked = 0;
  int unsigned n_sent = 0;
  int unsigned n_settings = 0;
  int unsigned src_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;

  msb_symbol_bucketer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bucket_t predict_bucket(input logic [DATA_W-1:0] value);
    logic [63:0] v;
    logic [63:0] thr;
    logic [63:0] bound;
    logic [63:0] sym;
    logic [63:0] base;
    logic [63:0] esc;
    int unsigned b;
    int unsigned sh;
    bit          passes;
    bucket_t     r;
    v = {32'b0, value};
    b = (cur_chunk == '0) ? 1 : int'(cur_chunk);
    thr = 64'd1 << b;
    passes = cur_incl ? (v <= thr) : (v < thr);
    sym = v;
    base = '0;
    sh = 0;
    if (!passes && cur_mode == MODE_MSB) begin
      bound = thr;
      while (cur_incl ? (v > bound) : (v >= bound)) begin
        sh += b;
        base += thr;
        bound = bound << b;
      end
      sym = (v >> sh) + base;
    end else if (!passes && cur_mode == MODE_MSB2) begin
      while (sym >= thr) begin
        sh++;
        base += thr;
        sym = sym >> 1;
      end
      sym = sym + base;
    end
    esc = v & ((64'd1 << sh) - 64'd1);
    r.coded_symbol  = sym[DATA_W-1:0];
    r.escape_bits   = esc[DATA_W-1:0];
    r.escape_length = LEN_W'(sh);
    return r;
  endfunction

  // values biased toward bucket edges and every magnitude
  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    int unsigned n;
    int unsigned b;
    int unsigned e;
    b = (cur_chunk == '0) ? 1 : int'(cur_chunk);
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1, 2: begin
        n = $urandom_range(1, 32);
        v = $urandom >> (32 - n);
        v[n-1] = 1'b1;
      end
      3: begin
        e = b * $urandom_range(1, 4);
        if (e > 31) v = '1;
        else v = (32'd1 << e) + $urandom_range(0, 2) - 32'd1;
      end
      4: v = $urandom_range(0, (b > 30) ? 32'hFFFF_FFFF : ((32'd1 << b) + 32'd1));
      default: v = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("tb: mismatch on %s, result %0d: got %h want %h", field, n_checked, got, want);
  endtask

  task automatic send_value(input logic [DATA_W-1:0] value);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    expected_buckets.push_back(predict_bucket(value));
    n_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_buckets.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SYMBOL_MODE:     cur_mode  = data[MODE_W-1:0];
      REG_CHUNK_BITS:      cur_chunk = data[CHUNK_W-1:0];
      REG_INCLUSIVE_BOUND: cur_incl  = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [MODE_W-1:0] mode, input logic [CHUNK_W-1:0] chunk,
                           input logic incl);
    settle();
    write_reg(REG_SYMBOL_MODE, CFG_W'(mode));
    write_reg(REG_CHUNK_BITS, CFG_W'(chunk));
    write_reg(REG_INCLUSIVE_BOUND, CFG_W'(incl));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic test_reset_defaults();
    send_value(32'h0000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0100);
    send_value(32'h0000_0101);
    apply_cfg(MODE_UNUSED, 5'd8, 1'b1);
    send_value(32'hFFFF_FFFF);
  endtask

  task automatic test_msb_chunks();
    apply_cfg(MODE_MSB, 5'd8, 1'b1);
    send_value(32'h0000_0100);
    send_value(32'h0000_0101);
    send_value(32'h0001_0000);
    send_value(32'h0001_0001);
    send_value(32'hFFFF_FFFF);
    // strict bound: threshold itself no longer passes
    apply_cfg(MODE_MSB, 5'd8, 1'b0);
    send_value(32'h0000_00FF);
    send_value(32'h0000_0100);
    send_value(32'h0001_0000);
  endtask

  task automatic test_msb_bitwise();
    apply_cfg(MODE_MSB2, 5'd8, 1'b1);
    send_value(32'h0000_0100);
    send_value(32'h0000_0101);
    send_value(32'hFFFF_FFFF);
    apply_cfg(MODE_MSB2, 5'd8, 1'b0);
    send_value(32'h0000_0100);
  endtask

  task automatic test_chunk_extremes();
    // zero width acts as one: longest bound walk
    apply_cfg(MODE_MSB, 5'd0, 1'b1);
    send_value(32'h0000_0003);
    send_value(32'hFFFF_FFFF);
    apply_cfg(MODE_MSB2, 5'd31, 1'b0);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    apply_cfg(MODE_MSB, 5'd24, 1'b1);
    send_value(32'h0100_0001);
    send_value(32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    apply_cfg(MODE_MSB2, 5'd1, 1'b1);
    src_idle_pct = 0;
    hold_len  <= RX_HOLD_CYCLES;
    hold_asks <= hold_asks + 1;
    repeat (12) send_value(rand_value());
    settle();
  endtask

  task automatic test_random_phase(input int unsigned src_pct, input int unsigned rcv_pct,
                                   input int unsigned items);
    logic [MODE_W-1:0]  mode;
    logic [CHUNK_W-1:0] chunk;
    int unsigned        pick;
    src_idle_pct = src_pct;
    rcv_idle_pct <= rcv_pct;
    for (int s = 0; s < 6; s++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) mode = MODE_DIRECT;
      else if (pick == 1) mode = MODE_UNUSED;
      else if (pick < 6) mode = MODE_MSB;
      else mode = MODE_MSB2;
      case ($urandom_range(0, 5))
        0: chunk = 5'd0;
        1: chunk = 5'd1;
        2: chunk = CHUNK_W'($urandom_range(24, 31));
        3: chunk = CHUNK_W'($urandom_range(0, 31));
        default: chunk = CHUNK_W'($urandom_range(1, 12));
      endcase
      apply_cfg(mode, chunk, 1'($urandom_range(0, 1)));
      repeat (items / 6) send_value(rand_value());
    end
  endtask

  // receiver: random stalls plus an on-request long hold-off
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_buckets.size() == 0) begin
        report_mismatch("unrequested result", m_axis_tdata[DATA_W-1:0], '0);
      end else begin
        want_b = expected_buckets.pop_front();
        if (m_axis_tdata[31:0] !== want_b.coded_symbol)
          report_mismatch("coded_symbol", m_axis_tdata[31:0], want_b.coded_symbol);
        if (m_axis_tdata[63:32] !== want_b.escape_bits)
          report_mismatch("escape_bits", m_axis_tdata[63:32], want_b.escape_bits);
        if (m_axis_tdata[69:64] !== want_b.escape_length)
          report_mismatch("escape_length", 32'(m_axis_tdata[69:64]),
                          32'(want_b.escape_length));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired, %0d results outstanding", expected_buckets.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_msb_chunks();
    test_msb_bitwise();
    test_chunk_extremes();
    test_backpressure();
    test_random_phase(14, 47, 360);
    test_random_phase(47, 14, 360);
    test_random_phase(0, 0, 360);

    settle();
    repeat (80) @(posedge clk_i);
    $display("tb: %0d values sent, %0d results compared, %0d register settings", n_sent,
             n_checked, n_settings);
    $display("tb: all three modes, both bound variants, chunk widths 0 to 31, stalls");
    if (mismatches == 0 && expected_buckets.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/msbb_pkg.sv
src/msbb_dpath.sv
src/msbb_seq.sv
src/msbb_out_stage.sv
src/msb_symbol_bucketer.sv
dv/msb_symbol_bucketer_tb.sv
